// File: src/wsfp_pkg.sv
// Package for the WebSocket frame parser: result codes, parser phases and
// the result record shared by the core, the output register and the top level.
// No dependencies.
`default_nettype none

package wsfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int KIND_W   = 2;
    localparam int CAUSE_W  = 2;
    localparam int LEN_W    = 64;
    localparam int KEY_W    = 32;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd3;

    localparam logic [CAUSE_W-1:0] CAUSE_RSV      = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_UNMASKED = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_CONT     = 2'd2;

    localparam logic [OPCODE_W-1:0] OPC_CONT = 4'h0;
    localparam logic [OPCODE_W-1:0] OPC_TEXT = 4'h1;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [2:0] EXT16_CNT = 3'd1;
    localparam logic [2:0] EXT64_CNT = 3'd7;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4,
        PH_ERR  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   data;
        logic [OPCODE_W-1:0] opcode;
        logic                eom;
        logic [CAUSE_W-1:0]  cause;
    } result_t;

endpackage

`default_nettype wire

// File: src/wsfp_if.sv
// Channel interfaces of the WebSocket frame parser: received bytes in,
// parse results out. Depends on wsfp_pkg.
`default_nettype none

interface wsfp_rx_if;
    import wsfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfp_res_if;
    import wsfp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   result_kind;
    logic [BYTE_W-1:0]   payload_data;
    logic [OPCODE_W-1:0] message_opcode;
    logic                end_of_message;
    logic [CAUSE_W-1:0]  error_cause;

    modport source (output valid, output result_kind, output payload_data,
                    output message_opcode, output end_of_message,
                    output error_cause, input ready);
    modport sink   (input valid, input result_kind, input payload_data,
                    input message_opcode, input end_of_message,
                    input error_cause, output ready);
endinterface

`default_nettype wire

// File: src/wsfp_in_reg.sv
// Input register of the WebSocket frame parser: holds one received byte
// until the core consumes it. Depends on wsfp_pkg.
`default_nettype none

module wsfp_in_reg (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  [wsfp_pkg::BYTE_W-1:0] in_byte,
    input  wire                        consume,
    output logic                       held_valid,
    output logic [wsfp_pkg::BYTE_W-1:0] held_byte
);
    import wsfp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign in_ready   = !valid_reg || consume;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

// File: src/wsfp_core.sv
// Frame parsing core: header state, length counter, mask key and the
// per-byte result logic, one byte per step. Depends on wsfp_pkg.
`default_nettype none

module wsfp_core (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire                         cfg_wdata,
    input  wire                         step,
    input  wire  [wsfp_pkg::BYTE_W-1:0] rx_byte,
    output logic                        res_valid,
    output wsfp_pkg::result_t           res
);
    import wsfp_pkg::*;

    phase_t              phase_reg,   phase_next;
    logic [2:0]          len_cnt_reg, len_cnt_next;
    logic [LEN_W-1:0]    remain_reg,  remain_next;
    logic [KEY_W-1:0]    key_reg,     key_next;
    logic [1:0]          idx_reg,     idx_next;
    logic                final_reg,   final_next;
    logic                masked_reg,  masked_next;
    logic [OPCODE_W-1:0] fopc_reg,    fopc_next;
    logic                frag_reg,    frag_next;
    logic [OPCODE_W-1:0] mopc_reg,    mopc_next;
    logic                mask_req_reg;

    logic                do_start;
    logic [OPCODE_W-1:0] tag;
    logic [BYTE_W-1:0]   key_byte;

    assign tag = (fopc_reg == OPC_CONT) ? mopc_reg : fopc_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        len_cnt_next = len_cnt_reg;
        remain_next  = remain_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        final_next   = final_reg;
        masked_next  = masked_reg;
        fopc_next    = fopc_reg;
        frag_next    = frag_reg;
        mopc_next    = mopc_reg;
        do_start     = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        case (phase_reg)
            PH_HDR0:
            begin
                final_next = rx_byte[7];
                fopc_next  = rx_byte[3:0];
                if (rx_byte[6:4] != 3'd0)
                begin
                    phase_next = PH_ERR;
                    res_valid  = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.opcode = rx_byte[3:0];
                    res.cause  = CAUSE_RSV;
                end
                else
                begin
                    phase_next = PH_HDR1;
                    if (frag_reg && rx_byte[3:0] != OPC_CONT && !rx_byte[3])
                    begin
                        frag_next  = 1'b0;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ABORT;
                        res.opcode = mopc_reg;
                    end
                end
            end
            PH_HDR1:
            begin
                masked_next = rx_byte[7];
                if (mask_req_reg && !rx_byte[7])
                begin
                    phase_next = PH_ERR;
                    res_valid  = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.opcode = fopc_reg;
                    res.cause  = CAUSE_UNMASKED;
                end
                else if (fopc_reg == OPC_CONT && !frag_reg)
                begin
                    phase_next = PH_ERR;
                    res_valid  = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.opcode = OPC_CONT;
                    res.cause  = CAUSE_CONT;
                end
                else
                begin
                    key_next = '0;
                    idx_next = 2'd0;
                    if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64)
                    begin
                        len_cnt_next = (rx_byte[6:0] == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
                        remain_next  = '0;
                        phase_next   = PH_EXT;
                    end
                    else
                    begin
                        remain_next = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
                        if (rx_byte[7])
                        begin
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            do_start = 1'b1;
                        end
                    end
                end
            end
            PH_EXT:
            begin
                remain_next = {remain_reg[LEN_W-BYTE_W-1:0], rx_byte};
                if (len_cnt_reg == 3'd0)
                begin
                    if (masked_reg)
                    begin
                        phase_next = PH_KEY;
                        idx_next   = 2'd0;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                else
                begin
                    len_cnt_next = len_cnt_reg - 3'd1;
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[KEY_W-BYTE_W-1:0], rx_byte};
                if (idx_reg == 2'd3)
                begin
                    do_start = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            PH_PAY:
            begin
                idx_next    = idx_reg + 2'd1;
                remain_next = remain_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                res_valid   = 1'b1;
                res.kind    = KIND_PAYLOAD;
                res.data    = rx_byte ^ key_byte;
                res.opcode  = tag;
                if (remain_reg == {{(LEN_W-1){1'b0}}, 1'b1})
                begin
                    phase_next = PH_HDR0;
                    res.eom    = final_reg;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (do_start)
        begin
            idx_next = 2'd0;
            if (!fopc_reg[3])
            begin
                if (fopc_reg != OPC_CONT)
                begin
                    if (!final_reg)
                    begin
                        frag_next = 1'b1;
                        mopc_next = fopc_reg;
                    end
                end
                else if (final_reg)
                begin
                    frag_next = 1'b0;
                end
            end
            if (remain_next == '0)
            begin
                phase_next = PH_HDR0;
                if (final_reg)
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_EMPTY_END;
                    res.opcode = tag;
                    res.eom    = 1'b1;
                end
            end
            else
            begin
                phase_next = PH_PAY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            len_cnt_reg  <= '0;
            remain_reg   <= '0;
            key_reg      <= '0;
            idx_reg      <= '0;
            final_reg    <= 1'b0;
            masked_reg   <= 1'b0;
            fopc_reg     <= OPC_CONT;
            frag_reg     <= 1'b0;
            mopc_reg     <= OPC_TEXT;
            mask_req_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                mask_req_reg <= cfg_wdata;
            end
            if (step)
            begin
                phase_reg   <= phase_next;
                len_cnt_reg <= len_cnt_next;
                remain_reg  <= remain_next;
                key_reg     <= key_next;
                idx_reg     <= idx_next;
                final_reg   <= final_next;
                masked_reg  <= masked_next;
                fopc_reg    <= fopc_next;
                frag_reg    <= frag_next;
                mopc_reg    <= mopc_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/wsfp_out_reg.sv
// Result register of the WebSocket frame parser: holds one result until the
// receiver takes it. Depends on wsfp_pkg.
`default_nettype none

module wsfp_out_reg (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                load,
    input  wire wsfp_pkg::result_t load_res,
    output logic               can_take,
    output logic               out_valid,
    input  wire                out_ready,
    output wsfp_pkg::result_t  out_res
);
    import wsfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

`default_nettype wire

// File: src/websocket_frame_parser.sv
// WebSocket frame parser, top level: input register, parsing core and
// result register. Depends on wsfp_pkg, wsfp_if, wsfp_in_reg, wsfp_core,
// wsfp_out_reg.
//
// Usage:
//   rx_ch carries the received stream one byte per transaction. res_ch
//   carries at most one result per byte: an unmasked payload byte, an empty
//   message end, an abort of a pending fragmented message, or a protocol
//   error with its cause. Header bytes give no other result.
//   cfg_we/cfg_wdata write mask_required; write it only while idle.
//   A byte waits in the input register, its result in the result register.
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   combinational parse step between input and result registers.
//   Reset clears both registers, returns the parser to the first header
//   byte and sets mask_required to 1.
//   When the receiver stalls, the result register holds, the core waits,
//   and rx_ch.ready drops once the input register is also full.
//   After a protocol error all further bytes are consumed without result
//   until reset.
`default_nettype none

module websocket_frame_parser (
    input  wire         clk,
    input  wire         rst_n,
    wsfp_rx_if.sink     rx_ch,
    wsfp_res_if.source  res_ch,
    input  wire         cfg_we,
    input  wire         cfg_wdata
);
    import wsfp_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              can_take;
    logic              step;
    logic              core_valid;
    result_t           core_res;
    logic              out_load;
    result_t           out_res;

    assign step     = held_valid && can_take;
    assign out_load = step && core_valid;

    wsfp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx_ch.valid),
        .in_ready   (rx_ch.ready),
        .in_byte    (rx_ch.rx_byte),
        .consume    (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    wsfp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .rx_byte   (held_byte),
        .res_valid (core_valid),
        .res       (core_res)
    );

    wsfp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_res  (core_res),
        .can_take  (can_take),
        .out_valid (res_ch.valid),
        .out_ready (res_ch.ready),
        .out_res   (out_res)
    );

    assign res_ch.result_kind    = out_res.kind;
    assign res_ch.payload_data   = out_res.data;
    assign res_ch.message_opcode = out_res.opcode;
    assign res_ch.end_of_message = out_res.eom;
    assign res_ch.error_cause    = out_res.cause;

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && core_res.kind == KIND_ERROR) |=> !out_load)
        else $error("result produced after protocol error");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && res_ch.valid && !res_ch.ready) |=> held_valid)
        else $error("input byte lost while result register stalled");

    a_eom_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && core_res.eom) |->
            (core_res.kind == KIND_PAYLOAD || core_res.kind == KIND_EMPTY_END))
        else $error("end of message on abort or error result");

    a_cause_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && core_res.kind != KIND_ERROR) |->
            (core_res.cause == CAUSE_RSV))
        else $error("error cause set on non-error result");

endmodule

`default_nettype wire

// File: sim/websocket_frame_parser_test.sv
`timescale 1ns / 1ps
// Testbench for websocket_frame_parser: directed and random WebSocket byte streams,
// with every parse result checked against a predictor of the frame decoder.
// Depends on wsfp_pkg, wsfp_if and the parser RTL.

module websocket_frame_parser_test;
    import wsfp_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int ITEM_TARGET   = 1950;
    localparam int PHASES        = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int PRINT_LIMIT   = 40;

    localparam logic [CAUSE_W-1:0]  CAUSE_NONE     = '0;
    localparam logic [OPCODE_W-1:0] OPC_BINARY     = 4'h2;
    localparam logic [OPCODE_W-1:0] OPC_RSVD_DATA  = 4'h3;
    localparam logic [OPCODE_W-1:0] OPC_DATA_LAST  = 4'h7;
    localparam logic [OPCODE_W-1:0] OPC_CTRL_FIRST = 4'h8;
    localparam logic [OPCODE_W-1:0] OPC_PING       = 4'h9;
    localparam logic [OPCODE_W-1:0] OPC_CTRL_LAST  = 4'hF;

    typedef enum int {LEN7, LEN16, LEN64} len_form_t;
    typedef enum int {END_RSV, END_UNMASKED, END_CONT, END_HUGE} ending_t;

    class frame_result_board;
        bit                  mask_required = 1'b1;
        phase_t              phase         = PH_HDR0;
        logic [2:0]          ext_left      = '0;
        logic [LEN_W-1:0]    remaining     = '0;
        logic [KEY_W-1:0]    key           = '0;
        logic [1:0]          key_pos       = '0;
        bit                  fin;
        bit                  masked;
        bit                  fragmented;
        logic [OPCODE_W-1:0] frame_opc     = OPC_CONT;
        logic [OPCODE_W-1:0] msg_opc       = OPC_TEXT;
        result_t             expected_q[$];
        int                  mismatches;

        function void set_mask_required(bit value);
            mask_required = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                           logic [OPCODE_W-1:0] opc, logic eom, logic [CAUSE_W-1:0] cause);
            result_t r;
            r = {kind, data, opc, eom, cause};
            expected_q.push_back(r);
        endfunction

        function logic [OPCODE_W-1:0] tag_opc();
            return (frame_opc == OPC_CONT) ? msg_opc : frame_opc;
        endfunction

        function void begin_payload();
            logic [OPCODE_W-1:0] t;
            t = tag_opc();
            key_pos = '0;
            if (!frame_opc[3])
            begin
                if (frame_opc != OPC_CONT)
                begin
                    if (!fin)
                    begin
                        fragmented = 1'b1;
                        msg_opc    = frame_opc;
                    end
                end
                else if (fin)
                    fragmented = 1'b0;
            end
            if (remaining == '0)
            begin
                phase = PH_HDR0;
                if (fin)
                    push(KIND_EMPTY_END, '0, t, 1'b1, CAUSE_NONE);
            end
            else
                phase = PH_PAY;
        endfunction

        function void after_length();
            if (masked)
            begin
                phase   = PH_KEY;
                key_pos = '0;
            end
            else
                begin_payload();
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] d;
            case (phase)
                PH_HDR0:
                begin
                    fin       = b[7];
                    frame_opc = b[3:0];
                    if (b[6:4] != 3'b000)
                    begin
                        phase = PH_ERR;
                        push(KIND_ERROR, '0, b[3:0], 1'b0, CAUSE_RSV);
                    end
                    else
                    begin
                        phase = PH_HDR1;
                        if (fragmented && b[3:0] != OPC_CONT && !b[3])
                        begin
                            fragmented = 1'b0;
                            push(KIND_ABORT, '0, msg_opc, 1'b0, CAUSE_NONE);
                        end
                    end
                end
                PH_HDR1:
                begin
                    masked = b[7];
                    if (mask_required && !masked)
                    begin
                        phase = PH_ERR;
                        push(KIND_ERROR, '0, frame_opc, 1'b0, CAUSE_UNMASKED);
                    end
                    else if (frame_opc == OPC_CONT && !fragmented)
                    begin
                        phase = PH_ERR;
                        push(KIND_ERROR, '0, OPC_CONT, 1'b0, CAUSE_CONT);
                    end
                    else
                    begin
                        key     = '0;
                        key_pos = '0;
                        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64)
                        begin
                            ext_left  = (b[6:0] == LEN_EXT16) ? EXT16_CNT : EXT64_CNT;
                            remaining = '0;
                            phase     = PH_EXT;
                        end
                        else
                        begin
                            remaining = {57'd0, b[6:0]};
                            after_length();
                        end
                    end
                end
                PH_EXT:
                begin
                    remaining = {remaining[LEN_W-9:0], b};
                    if (ext_left == 3'd0)
                        after_length();
                    else
                        ext_left = ext_left - 3'd1;
                end
                PH_KEY:
                begin
                    key = {key[KEY_W-9:0], b};
                    if (key_pos == 2'd3)
                        begin_payload();
                    else
                        key_pos = key_pos + 2'd1;
                end
                PH_PAY:
                begin
                    d         = b ^ key[8 * (3 - key_pos) +: 8];
                    key_pos   = key_pos + 2'd1;
                    remaining = remaining - 1;
                    if (remaining == '0)
                        phase = PH_HDR0;
                    push(KIND_PAYLOAD, d, tag_opc(), remaining == '0 && fin, CAUSE_NONE);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void report(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: result expected none, got %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)     report("result_kind", want.kind, got.kind);
            if (got.data !== want.data)     report("payload_data", want.data, got.data);
            if (got.opcode !== want.opcode) report("message_opcode", want.opcode, got.opcode);
            if (got.eom !== want.eom)       report("end_of_message", want.eom, got.eom);
            if (got.cause !== want.cause)   report("error_cause", want.cause, got.cause);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    wsfp_rx_if   rx_ch ();
    wsfp_res_if  res_ch ();

    frame_result_board board = new;
    int          bytes_sent;
    int          burst_left;
    bit          no_gaps;
    bit          gen_frag;
    bit          hold_request;
    int unsigned cycle_count;

    websocket_frame_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_ch     (rx_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rx_ch.valid && rx_ch.ready)
            board.note_byte(rx_ch.rx_byte);
    end

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.result_kind, res_ch.payload_data, res_ch.message_opcode,
                   res_ch.end_of_message, res_ch.error_cause};
            board.check_result(got);
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= value;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit fin, input logic [OPCODE_W-1:0] opc, input bit masked,
                              input logic [LEN_W-1:0] len, input len_form_t form,
                              input int fill = -1, input int body = -1);
        logic [6:0] len7;
        int         count;
        count = (body < 0) ? int'(len) : body;
        case (form)
            LEN16:   len7 = LEN_EXT16;
            LEN64:   len7 = LEN_EXT64;
            default: len7 = len[6:0];
        endcase
        send_byte({fin, 3'b000, opc});
        send_byte({masked, len7});
        if (form == LEN16)
        begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else if (form == LEN64)
            for (int i = 7; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        if (masked)
            repeat (4) send_byte(fill < 0 ? rand_byte() : 8'(fill));
        repeat (count) send_byte(fill < 0 ? rand_byte() : 8'(fill));
        if (!opc[3])
        begin
            if (opc != OPC_CONT)
                gen_frag = !fin;
            else if (fin)
                gen_frag = 1'b0;
        end
    endtask

    task automatic send_random_frame(input bit allow_unmasked);
        logic [OPCODE_W-1:0] opc;
        bit                  fin;
        bit                  masked;
        int                  pick;
        int                  len;
        len_form_t           form;
        pick = $urandom_range(0, 99);
        if (gen_frag && pick < 55)
            opc = OPC_CONT;
        else if (pick < 75)
            opc = 4'($urandom_range(OPC_TEXT, OPC_BINARY));
        else if (pick < 82)
            opc = 4'($urandom_range(OPC_RSVD_DATA, OPC_DATA_LAST));
        else
            opc = 4'($urandom_range(OPC_CTRL_FIRST, OPC_CTRL_LAST));
        fin    = ($urandom_range(0, 2) != 0);
        masked = allow_unmasked ? 1'($urandom_range(0, 1)) : 1'b1;
        pick   = $urandom_range(0, 19);
        if (pick < 15)
        begin
            form = LEN7;
            len  = $urandom_range(0, 8);
        end
        else if (pick == 15)
        begin
            form = LEN7;
            len  = $urandom_range(0, 125);
        end
        else if (pick < 19)
        begin
            form = LEN16;
            len  = $urandom_range(0, pick == 18 ? 300 : 20);
        end
        else
        begin
            form = LEN64;
            len  = $urandom_range(0, 20);
        end
        send_frame(fin, opc, masked, 64'(len), form);
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask_required(input bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        board.set_mask_required(value);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : receiver
        int mode;
        int span;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_request)
                begin
                    // hold off long enough for the parser to back up into rx_ch
                    hold_request = 1'b0;
                    res_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 1) == 1);
                    2:       res_ch.ready <= ($urandom_range(0, 4) != 0);
                    default: res_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int      phase_start;
        ending_t ending;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short frames, mostly unmasked: fragments, control in between, abort, empty ends
        write_mask_required(1'b0);
        send_frame(1'b0, OPC_TEXT, 1'b0, 64'd2, LEN7, 255);
        send_frame(1'b1, OPC_PING, 1'b0, 64'd0, LEN7);
        send_frame(1'b0, OPC_CONT, 1'b0, 64'd1, LEN7, 0);
        send_frame(1'b1, OPC_BINARY, 1'b0, 64'd1, LEN7);
        send_frame(1'b0, OPC_RSVD_DATA, 1'b0, 64'd0, LEN7);
        send_frame(1'b0, OPC_CTRL_LAST, 1'b0, 64'd0, LEN7);
        send_frame(1'b1, OPC_CONT, 1'b0, 64'd0, LEN7);
        send_frame(1'b1, OPC_TEXT, 1'b1, 64'd1, LEN16, 255);
        send_frame(1'b1, OPC_BINARY, 1'b0, 64'd1, LEN64);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_mask_required(p % 2 == 0);
            if (p == 2)
                hold_request = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent < phase_start + ITEM_TARGET / PHASES)
            begin
                no_gaps = (p == 2) && (bytes_sent < phase_start + 120);
                send_random_frame(p % 2 != 0);
            end
        end
        no_gaps = 1'b0;

        // close with a sticky error or a frame too long to ever finish
        wait_drained();
        write_mask_required(1'b1);
        ending = ending_t'($urandom_range(END_RSV, END_HUGE));
        case (ending)
            END_RSV:
                send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                           4'($urandom_range(0, 15))});
            END_UNMASKED:
            begin
                send_byte({1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))});
                send_byte({1'b0, 7'($urandom_range(0, 127))});
            end
            END_CONT:
            begin
                if (gen_frag)
                    send_frame(1'b1, OPC_CONT, 1'b1, 64'd0, LEN7);
                send_byte({1'($urandom_range(0, 1)), 3'b000, OPC_CONT});
                send_byte({1'b1, 7'($urandom_range(0, 127))});
            end
            default:
                send_frame(1'($urandom_range(0, 1)),
                           4'($urandom_range(OPC_TEXT, OPC_CTRL_LAST)), 1'b1,
                           {1'b1, 31'($urandom), 32'($urandom)}, LEN64, -1, 24);
        endcase
        repeat (8) send_byte(rand_byte());

        wait_drained();
        if (board.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
